[sv/swmn_pkg.sv]
// Shared types and constants of the sliding-window min/max normalizer.
package swmn_pkg;

   localparam int SampleW          = 32;
   localparam int ValueW           = 16;
   localparam int PosW             = 6;
   localparam int RspDataW         = 24;
   localparam int AvgSpan          = 5;
   localparam int MinDiscardWindow = 10;
   localparam int QOne             = 32768;
   localparam int AccW             = 20;
   localparam int CheckW           = 4;
   localparam int RecipW           = 22;
   localparam int ShiftW           = 5;
   localparam int NumW             = 49;
   localparam int NtW              = 21;
   localparam int ProdW            = 43;
   localparam int QW               = 17;
   localparam int UW               = 18;
   localparam int QueueDepth       = 2;
   localparam int QPtrW            = $clog2(QueueDepth);
   localparam int QCntW            = $clog2(QueueDepth + 1);

   localparam logic [ValueW-1:0]     ValueMax     = 16'h7FFF;
   localparam logic signed [AccW-1:0] DropLimit   = AccW'(AvgSpan * QOne);
   localparam logic signed [AccW-1:0] NegDropLimit = -AccW'(AvgSpan * QOne);

   typedef struct packed {
      logic [SampleW-1:0] sample;
      logic               emit;
   } queue_entry_type;

   typedef struct packed {
      logic               start;
      logic [SampleW-1:0] divisor;
   } recip_req_type;

   typedef struct packed {
      logic              done;
      logic [RecipW-1:0] recip;
      logic [ShiftW-1:0] shift;
   } recip_rsp_type;

endpackage

[sv/swmn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module swmn_ram #(
   parameter int Width = 32,
   parameter int Depth = 32,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/swmn_recip.sv]
// Serial reciprocal unit: normalizes the range and divides 2^52 by it, one bit a cycle.
module swmn_recip (
   input  logic                   clock,
   input  logic                   reset,
   input  swmn_pkg::recip_req_type req,
   output swmn_pkg::recip_rsp_type rsp
);

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_NORM = 2'd1;
   localparam logic [1:0] R_DIV  = 2'd2;

   localparam int PW = swmn_pkg::SampleW + 1;
   localparam logic [PW-1:0] PStart = PW'(64'h4000_0000);

   logic [1:0]                    state_ff, state_in;
   logic [swmn_pkg::SampleW-1:0]  rn_ff, rn_in;
   logic [swmn_pkg::ShiftW-1:0]   sh_ff, sh_in;
   logic [PW-1:0]                 p_ff, p_in;
   logic [swmn_pkg::RecipW-1:0]   q_ff, q_in;
   logic [swmn_pkg::ShiftW-1:0]   it_ff, it_in;
   logic                          done_ff, done_in;
   logic [PW-1:0]                 p2;

   assign p2 = {p_ff[PW-2:0], 1'b0};

   always_comb begin
      state_in = state_ff;
      rn_in    = rn_ff;
      sh_in    = sh_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      it_in    = it_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         R_IDLE: begin
            if (req.start) begin
               rn_in    = req.divisor;
               sh_in    = '0;
               state_in = R_NORM;
            end
         end
         R_NORM: begin
            if (rn_ff[swmn_pkg::SampleW-1]) begin
               p_in     = PStart;
               it_in    = swmn_pkg::ShiftW'(swmn_pkg::RecipW - 1);
               state_in = R_DIV;
            end else begin
               rn_in = {rn_ff[swmn_pkg::SampleW-2:0], 1'b0};
               sh_in = sh_ff + 1'b1;
            end
         end
         R_DIV: begin
            if (p2 >= {1'b0, rn_ff}) begin
               p_in = p2 - {1'b0, rn_ff};
               q_in = {q_ff[swmn_pkg::RecipW-2:0], 1'b1};
            end else begin
               p_in = p2;
               q_in = {q_ff[swmn_pkg::RecipW-2:0], 1'b0};
            end
            if (it_ff == '0) begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else begin
               it_in = it_ff - 1'b1;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rn_ff <= rn_in;
      sh_ff <= sh_in;
      p_ff  <= p_in;
      q_ff  <= q_in;
      it_ff <= it_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.recip = q_ff;
   assign rsp.shift = sh_ff;

endmodule

[sv/swmn_queue.sv]
// Short word queue between the front and back parts.
module swmn_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  swmn_pkg::queue_entry_type push_entry,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output swmn_pkg::queue_entry_type pop_entry
);

   localparam logic [swmn_pkg::QPtrW-1:0] LastPtr = swmn_pkg::QPtrW'(swmn_pkg::QueueDepth - 1);
   localparam logic [swmn_pkg::QCntW-1:0] Full    = swmn_pkg::QCntW'(swmn_pkg::QueueDepth);

   swmn_pkg::queue_entry_type           entries_ff [swmn_pkg::QueueDepth];
   logic [swmn_pkg::QPtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [swmn_pkg::QPtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [swmn_pkg::QCntW-1:0]          count_ff, count_in;
   logic                                push, pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/swmn_front.sv]
// Front part: accepts sample words, tracks the fill count and tags window-complete words.
module swmn_front #(
   parameter int WINDOW = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [swmn_pkg::SampleW-1:0] req_tdata,
   output logic                         q_valid,
   input  logic                         q_ready,
   output swmn_pkg::queue_entry_type    q_entry
);

   localparam int CntW = $clog2(WINDOW + 1);
   localparam logic [CntW-1:0] FillMax  = CntW'(WINDOW);
   localparam logic [CntW-1:0] FillLast = CntW'(WINDOW - 1);

   logic [CntW-1:0] fill_ff, fill_in;
   logic            accept;

   assign req_tready     = q_ready;
   assign q_valid        = req_tvalid;
   assign accept         = req_tvalid && q_ready;
   assign q_entry.sample = req_tdata;
   assign q_entry.emit   = (fill_ff >= FillLast);

   always_comb begin
      fill_in = fill_ff;
      if (accept && (fill_ff != FillMax)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

[sv/swmn_back.sv]
// Back part: stores samples, scans min/max, normalizes, checks start/end means and emits words.
module swmn_back #(
   parameter int WINDOW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic                          csr_wdata,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  swmn_pkg::queue_entry_type     q_entry,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swmn_pkg::ValueW-1:0]   rsp_value,
   output logic [swmn_pkg::PosW-1:0]     rsp_position,
   output logic                          rsp_last
);

   localparam int AddrW = $clog2(WINDOW);
   localparam int CntW  = $clog2(WINDOW + 1);
   localparam logic [AddrW:0]   WinExt   = (AddrW + 1)'(WINDOW);
   localparam logic [CntW-1:0]  ScanEnd  = CntW'(WINDOW);
   localparam logic [AddrW-1:0] LastIdx  = AddrW'(WINDOW - 1);
   localparam logic [AddrW-1:0] TailBase = AddrW'(WINDOW - 2 * swmn_pkg::AvgSpan);
   localparam logic DoCheck = (WINDOW >= swmn_pkg::MinDiscardWindow);
   localparam logic [swmn_pkg::CheckW-1:0] HeadEnd  = swmn_pkg::CheckW'(swmn_pkg::AvgSpan);
   localparam logic [swmn_pkg::CheckW-1:0] CheckEnd =
      swmn_pkg::CheckW'(2 * swmn_pkg::AvgSpan - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_RANGE = 3'd2;
   localparam logic [2:0] S_RECIP = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   localparam logic [2:0] P_READ = 3'd0;
   localparam logic [2:0] P_NUM  = 3'd1;
   localparam logic [2:0] P_MUL  = 3'd2;
   localparam logic [2:0] P_FIX  = 3'd3;
   localparam logic [2:0] P_DONE = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [2:0]                          ph_ff, ph_in;
   logic                                discard_ff, discard_in;
   logic [AddrW-1:0]                    wp_ff, wp_in;
   logic [AddrW-1:0]                    oldest_ff, oldest_in;
   logic [CntW-1:0]                     sc_ff, sc_in;
   logic signed [swmn_pkg::SampleW-1:0] lo_ff, lo_in;
   logic signed [swmn_pkg::SampleW-1:0] hi_ff, hi_in;
   logic [swmn_pkg::SampleW-1:0]        r_ff, r_in;
   logic                                flat_ff, flat_in;
   logic [swmn_pkg::CheckW-1:0]         k_ff, k_in;
   logic [AddrW-1:0]                    j_ff, j_in;
   logic signed [swmn_pkg::AccW-1:0]    acc_ff, acc_in;
   logic [swmn_pkg::NumW-1:0]           num_ff, num_in;
   logic [swmn_pkg::NtW-1:0]            nt_ff, nt_in;
   logic [swmn_pkg::ProdW-1:0]          prod_ff, prod_in;
   logic [swmn_pkg::QW-1:0]             qest_ff, qest_in;
   logic [swmn_pkg::NumW-1:0]           qr_ff, qr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [swmn_pkg::ValueW-1:0]         rsp_value_ff, rsp_value_in;
   logic [swmn_pkg::PosW-1:0]           rsp_pos_ff, rsp_pos_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                wr_en, rd_en;
   logic [AddrW-1:0]                    rd_addr;
   logic [swmn_pkg::SampleW-1:0]        rd_data;
   logic [AddrW-1:0]                    wp_inc;
   logic [AddrW-1:0]                    idx;
   logic [AddrW:0]                      elem_sum;
   logic [AddrW-1:0]                    elem_addr;
   logic [swmn_pkg::SampleW-1:0]        range;
   logic [swmn_pkg::SampleW-1:0]        elem_off;
   logic [swmn_pkg::NumW-1:0]           num;
   logic [swmn_pkg::NumW-1:0]           num_sh;
   logic [swmn_pkg::NumW-1:0]           rem;
   logic [swmn_pkg::QW-1:0]             qfin;
   logic signed [swmn_pkg::UW-1:0]      u_val;
   logic [swmn_pkg::ValueW-1:0]         value_sat;
   logic signed [swmn_pkg::AccW-1:0]    u_ext;
   logic signed [swmn_pkg::AccW-1:0]    acc_next;
   logic                                drop;
   logic                                check_on;
   logic                                can_load;
   swmn_pkg::recip_req_type             recip_req;
   swmn_pkg::recip_rsp_type             recip_rsp;

   swmn_ram #(
      .Width (swmn_pkg::SampleW),
      .Depth (WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (q_entry.sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   swmn_recip u_recip (
      .clock (clock),
      .reset (reset),
      .req   (recip_req),
      .rsp   (recip_rsp)
   );

   assign q_ready  = (state_ff == S_IDLE);
   assign wr_en    = q_ready && q_valid;
   assign wp_inc   = (wp_ff == LastIdx) ? '0 : wp_ff + 1'b1;
   assign check_on = discard_ff && DoCheck;
   assign can_load = !rsp_valid_ff || rsp_ready;

   // element index: head and tail of the window in check mode, running index in emit mode
   always_comb begin
      if (state_ff == S_CHECK) begin
         idx = (k_ff < HeadEnd) ? AddrW'(k_ff) : TailBase + AddrW'(k_ff);
      end else begin
         idx = j_ff;
      end
   end

   assign elem_sum  = {1'b0, oldest_ff} + {1'b0, idx};
   assign elem_addr = (elem_sum >= WinExt) ? AddrW'(elem_sum - WinExt) : elem_sum[AddrW-1:0];

   assign rd_en   = ((state_ff == S_SCAN) && (sc_ff != ScanEnd)) ||
                    (((state_ff == S_CHECK) || (state_ff == S_EMIT)) && (ph_ff == P_READ));
   assign rd_addr = (state_ff == S_SCAN) ? sc_ff[AddrW-1:0] : elem_addr;

   assign range             = hi_ff - lo_ff;
   assign recip_req.start   = (state_ff == S_RANGE) && (range != '0);
   assign recip_req.divisor = range;

   // numerator d*2^16 + r/2, aligned to the normalized range
   assign elem_off = rd_data - lo_ff;
   assign num      = {1'b0, elem_off, 16'b0} + swmn_pkg::NumW'(r_ff[swmn_pkg::SampleW-1:1]);
   assign num_sh   = num << recip_rsp.shift;

   assign rem       = num_ff - qr_ff;
   assign qfin      = qest_ff + swmn_pkg::QW'(rem >= {17'b0, r_ff});
   assign u_val     = flat_ff ? '0 : swmn_pkg::UW'(qfin) - swmn_pkg::UW'(swmn_pkg::QOne);
   assign value_sat = (u_val == swmn_pkg::UW'(swmn_pkg::QOne)) ? swmn_pkg::ValueMax
                                                                : u_val[swmn_pkg::ValueW-1:0];
   assign u_ext     = {{(swmn_pkg::AccW - swmn_pkg::UW){u_val[swmn_pkg::UW-1]}}, u_val};
   assign acc_next  = (k_ff < HeadEnd) ? acc_ff + u_ext : acc_ff - u_ext;
   assign drop      = (acc_next > swmn_pkg::DropLimit) || (acc_next < swmn_pkg::NegDropLimit);

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      discard_in   = csr_wen ? csr_wdata : discard_ff;
      wp_in        = wp_ff;
      oldest_in    = oldest_ff;
      sc_in        = sc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      r_in         = r_ff;
      flat_in      = flat_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      nt_in        = nt_ff;
      prod_in      = prod_ff;
      qest_in      = qest_ff;
      qr_in        = qr_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               wp_in     = wp_inc;
               oldest_in = wp_inc;
               sc_in     = '0;
               if (q_entry.emit) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sc_ff == CntW'(1)) begin
               lo_in = rd_data;
               hi_in = rd_data;
            end else if (sc_ff != '0) begin
               if ($signed(rd_data) < lo_ff) begin
                  lo_in = rd_data;
               end
               if ($signed(rd_data) > hi_ff) begin
                  hi_in = rd_data;
               end
            end
            if (sc_ff == ScanEnd) begin
               state_in = S_RANGE;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         S_RANGE: begin
            r_in    = range;
            flat_in = (range == '0);
            acc_in  = '0;
            k_in    = '0;
            j_in    = '0;
            ph_in   = P_READ;
            if (range != '0) begin
               state_in = S_RECIP;
            end else begin
               state_in = check_on ? S_CHECK : S_EMIT;
            end
         end
         S_RECIP: begin
            if (recip_rsp.done) begin
               state_in = check_on ? S_CHECK : S_EMIT;
            end
         end
         S_CHECK, S_EMIT: begin
            unique case (ph_ff)
               P_READ: begin
                  ph_in = P_NUM;
               end
               P_NUM: begin
                  num_in = num;
                  nt_in  = num_sh[swmn_pkg::NumW-1 -: swmn_pkg::NtW];
                  ph_in  = P_MUL;
               end
               P_MUL: begin
                  prod_in = nt_ff * recip_rsp.recip;
                  ph_in   = P_FIX;
               end
               P_FIX: begin
                  qest_in = prod_ff[swmn_pkg::QW+23:24];
                  qr_in   = prod_ff[swmn_pkg::QW+23:24] * r_ff;
                  ph_in   = P_DONE;
               end
               P_DONE: begin
                  if (state_ff == S_CHECK) begin
                     acc_in = acc_next;
                     ph_in  = P_READ;
                     if (k_ff == CheckEnd) begin
                        state_in = drop ? S_IDLE : S_EMIT;
                     end else begin
                        k_in = k_ff + 1'b1;
                     end
                  end else if (can_load) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = value_sat;
                     rsp_pos_in   = swmn_pkg::PosW'(j_ff);
                     rsp_last_in  = (j_ff == LastIdx);
                     ph_in        = P_READ;
                     if (j_ff == LastIdx) begin
                        state_in = S_IDLE;
                     end else begin
                        j_in = j_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  ph_in = P_READ;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= P_READ;
         discard_ff   <= 1'b1;
         wp_ff        <= '0;
         oldest_ff    <= '0;
         sc_ff        <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         flat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         discard_ff   <= discard_in;
         wp_ff        <= wp_in;
         oldest_ff    <= oldest_in;
         sc_ff        <= sc_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         flat_ff      <= flat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      r_ff         <= r_in;
      acc_ff       <= acc_in;
      num_ff       <= num_in;
      nt_ff        <= nt_in;
      prod_ff      <= prod_in;
      qest_ff      <= qest_in;
      qr_ff        <= qr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last     = rsp_last_ff;

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RANGE |-> hi_ff >= lo_ff)
      else $error("window maximum below minimum");

   a_single_fix: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CHECK) || (state_ff == S_EMIT)) && (ph_ff == P_DONE) && !flat_ff
      |-> rem < {16'b0, r_ff, 1'b0})
      else $error("quotient estimate off by more than one");

   a_recip_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RECIP) && recip_rsp.done
      |-> recip_rsp.recip[swmn_pkg::RecipW-1] || recip_rsp.recip[swmn_pkg::RecipW-2])
      else $error("reciprocal out of range");

endmodule

[sv/sliding_window_minmax_normalizer_core.sv]
// Sliding-window min/max normalizer: top level.
// Takes one signed Q16.16 sample word at a time and keeps the last WINDOW samples. Once the
// window is full, every sample produces WINDOW normalized Q1.15 words, oldest first, with
// tlast on the final one, unless the start/end mean check drops the window. A sample that
// does not complete a window is only stored in the back part. A complete window goes through
// the min/max scan over the sample RAM's single read port, the serial reciprocal unit unless
// the range is zero (one bit a cycle for the range normalization, then 22 quotient bits), and
// the shared normalize sequence (read, numerator, multiply, fix, done) for every element: 10
// elements for the mean check when enabled, then WINDOW elements for output. The two-entry
// queue lets new samples be taken while a window is still being worked off, and the output
// register holds a word while the next one is computed.
module sliding_window_minmax_normalizer_core #(
   parameter int WINDOW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic                          csr_wdata,       // discard_enable
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [swmn_pkg::SampleW-1:0]  req_tdata,       // [31:0] sample
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [swmn_pkg::RspDataW-1:0] rsp_tdata,       // [15:0] value, [21:16] position
   output logic                          rsp_tlast
);

   logic                        q_in_valid, q_in_ready;
   logic                        q_out_valid, q_out_ready;
   swmn_pkg::queue_entry_type   q_in_entry, q_out_entry;
   logic [swmn_pkg::ValueW-1:0] rsp_value;
   logic [swmn_pkg::PosW-1:0]   rsp_position;

   swmn_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_in_valid),
      .q_ready    (q_in_ready),
      .q_entry    (q_in_entry)
   );

   swmn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_entry (q_in_entry),
      .pop_valid  (q_out_valid),
      .pop_ready  (q_out_ready),
      .pop_entry  (q_out_entry)
   );

   swmn_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .q_valid      (q_out_valid),
      .q_ready      (q_out_ready),
      .q_entry      (q_out_entry),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {{(swmn_pkg::RspDataW - swmn_pkg::ValueW - swmn_pkg::PosW){1'b0}},
                       rsp_position, rsp_value};

endmodule

[tb/sv/sliding_window_minmax_normalizer_core_tb.sv]
// Self-checking testbench for the sliding-window min/max normalizer core.
module sliding_window_minmax_normalizer_core_tb;

   localparam int Window      = 32;
   localparam int DrainCycles = 3 * (6 * Window + 120);
   localparam int CycleLimit  = 2_000_000;
   localparam int HoldOff     = 700;
   localparam int DueDepth    = 1024;

   typedef struct packed {
      logic [swmn_pkg::ValueW-1:0] value;
      logic [swmn_pkg::PosW-1:0]   position;
      logic                        last;
   } norm_word_type;

   typedef enum int {ModeWide, ModeNarrow, ModeRamp, ModeHold, ModeExtreme} sample_mode_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          csr_wen    = 1'b0;
   logic                          csr_wdata  = 1'b0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [swmn_pkg::SampleW-1:0]  req_tdata  = '0;      // [31:0] sample
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [swmn_pkg::RspDataW-1:0] rsp_tdata;             // [15:0] value, [21:16] position
   logic                          rsp_tlast;

   logic signed [swmn_pkg::SampleW-1:0] window_samples [Window];
   int                                  fill_level = 0;
   int                                  write_slot = 0;
   logic                                discard_on = 1'b1;
   norm_word_type                       due_words [DueDepth];
   int                                  due_head = 0;
   int                                  due_tail = 0;
   norm_word_type                       due_word;

   int     req_idle_pct    = 15;
   int     rsp_idle_pct    = 15;
   int     rsp_hold_left   = 0;
   int     failures        = 0;
   int     samples_sent    = 0;
   int     words_checked   = 0;
   int     windows_emitted = 0;
   int     windows_dropped = 0;
   longint cycle_count     = 0;

   logic [swmn_pkg::SampleW-1:0] prev_sample = '0;
   logic [swmn_pkg::SampleW-1:0] burst_base  = '0;
   logic [swmn_pkg::SampleW-1:0] burst_step  = '0;

   sliding_window_minmax_normalizer_core #(
      .WINDOW(Window)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_tail == due_head) begin
            $error("unexpected word: value %0d position %0d last %0b",
                   $signed(rsp_tdata[swmn_pkg::ValueW-1:0]),
                   rsp_tdata[swmn_pkg::ValueW +: swmn_pkg::PosW], rsp_tlast);
            failures++;
         end else begin
            due_word = due_words[due_head % DueDepth];
            due_head++;
            words_checked++;
            if (rsp_tdata[swmn_pkg::ValueW-1:0] !== due_word.value) begin
               $error("value: expected %0d, actual %0d",
                      $signed(due_word.value), $signed(rsp_tdata[swmn_pkg::ValueW-1:0]));
               failures++;
            end
            if (rsp_tdata[swmn_pkg::ValueW +: swmn_pkg::PosW] !== due_word.position) begin
               $error("position: expected %0d, actual %0d",
                      due_word.position, rsp_tdata[swmn_pkg::ValueW +: swmn_pkg::PosW]);
               failures++;
            end
            if (rsp_tlast !== due_word.last) begin
               $error("last: expected %0b, actual %0b", due_word.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   function automatic void predict_words(input logic signed [swmn_pkg::SampleW-1:0] sample);
      logic signed [swmn_pkg::SampleW-1:0] lo;
      logic signed [swmn_pkg::SampleW-1:0] hi;
      longint                              span;
      longint                              offset;
      int                                  u [Window];
      int                                  sum_old;
      int                                  sum_new;
      int                                  gap;
      int                                  slot;
      int                                  k;
      norm_word_type                       word;
      window_samples[write_slot] = sample;
      write_slot = (write_slot + 1) % Window;
      if (fill_level < Window)
         fill_level++;
      if (fill_level < Window)
         return;
      lo = window_samples[0];
      hi = window_samples[0];
      for (k = 1; k < Window; k++) begin
         if (window_samples[k] < lo)
            lo = window_samples[k];
         if (window_samples[k] > hi)
            hi = window_samples[k];
      end
      span = longint'(hi) - longint'(lo);
      slot = write_slot;
      for (k = 0; k < Window; k++) begin
         offset = longint'(window_samples[slot]) - longint'(lo);
         u[k]   = (span == 0) ? 0 :
                  int'((offset * 65536 + span / 2) / span) - swmn_pkg::QOne;
         slot   = (slot + 1) % Window;
      end
      if (discard_on && Window >= swmn_pkg::MinDiscardWindow) begin
         sum_old = 0;
         sum_new = 0;
         for (k = 0; k < swmn_pkg::AvgSpan; k++) begin
            sum_old += u[k];
            sum_new += u[Window-1-k];
         end
         gap = sum_old - sum_new;
         if (gap < 0)
            gap = -gap;
         if (gap > swmn_pkg::AvgSpan * swmn_pkg::QOne) begin
            windows_dropped++;
            return;
         end
      end
      for (k = 0; k < Window; k++) begin
         word.value    = (u[k] > swmn_pkg::QOne - 1) ? swmn_pkg::ValueW'(swmn_pkg::QOne - 1)
                                                     : swmn_pkg::ValueW'(u[k]);
         word.position = swmn_pkg::PosW'(k);
         word.last     = (k == Window - 1);
         due_words[due_tail % DueDepth] = word;
         due_tail++;
      end
      windows_emitted++;
   endfunction

   function automatic logic [swmn_pkg::SampleW-1:0] pick_sample(input sample_mode_type mode);
      case (mode)
         ModeWide:   return $urandom;
         ModeNarrow: return burst_base + $urandom_range(0, 4095);
         ModeRamp:   return prev_sample + burst_step;
         ModeHold:   return prev_sample;
         default: begin
            case ($urandom_range(3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic send_sample(input logic [swmn_pkg::SampleW-1:0] sample);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_words(sample);
      prev_sample = sample;
      samples_sent++;
   endtask

   task automatic drain_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_tail != due_head)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_discard(input logic enable);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= enable;
      @(negedge clock);
      csr_wen   <= 1'b0;
      discard_on = enable;
   endtask

   task automatic test_fill_and_extremes();
      logic [swmn_pkg::SampleW-1:0] corners [9] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                                    32'h0000_0000, 32'hFFFF_FFFF,
                                                    32'h0000_0001, 32'h5555_5555,
                                                    32'hAAAA_AAAA, 32'h7FFF_FFFE,
                                                    32'h8000_0001};
      write_discard(1'b0);
      foreach (corners[k])
         send_sample(corners[k]);
      repeat (Window - 9) send_sample($urandom);
   endtask

   task automatic test_flat_window();
      logic [swmn_pkg::SampleW-1:0] level;
      level = $urandom;
      repeat (Window) send_sample(level);
      send_sample(level + 1);
      send_sample(level - 1);
      send_sample(level);
   endtask

   task automatic test_discard_check();
      int k;
      drain_block();
      write_discard(1'b1);
      burst_base = $urandom_range(0, 32'h0FFF_FFFF);
      for (k = 0; k < Window; k++)
         send_sample(burst_base + k * 32'h0001_0000);
      // hold the sender until every word is out
      drain_block();
   endtask

   task automatic test_discard_off();
      int k;
      drain_block();
      write_discard(1'b0);
      for (k = 0; k < 20; k++)
         send_sample(burst_base - k * 32'h0003_0000);
   endtask

   task automatic test_output_backpressure();
      drain_block();
      rsp_hold_left = HoldOff;
      repeat (8) send_sample($urandom);
   endtask

   task automatic run_random_phase(input logic enable, input int items, input bit no_idle);
      int              sent;
      int              burst_len;
      int              pick;
      sample_mode_type mode;
      drain_block();
      write_discard(enable);
      if (no_idle) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 35)
            mode = ModeWide;
         else if (pick < 60)
            mode = ModeNarrow;
         else if (pick < 80)
            mode = ModeRamp;
         else if (pick < 90)
            mode = ModeHold;
         else
            mode = ModeExtreme;
         burst_len  = (mode == ModeHold) ? $urandom_range(8, 40) : $urandom_range(1, 24);
         burst_base = $urandom;
         burst_step = $urandom_range(1, 32'h00FF_FFFF);
         if ($urandom_range(1))
            burst_step = -burst_step;
         repeat (burst_len) begin
            if (sent < items) begin
               send_sample(pick_sample(mode));
               sent++;
            end
         end
      end
      req_idle_pct = 15;
      rsp_idle_pct = 15;
   endtask

   task automatic test_random_phases();
      run_random_phase(1'b1, 70, 1'b0);
      run_random_phase(1'b0, 70, 1'b1);
      run_random_phase(1'b1, 70, 1'b0);
      run_random_phase(1'b0, 70, 1'b0);
   endtask

   initial begin
      foreach (window_samples[k])
         window_samples[k] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_fill_and_extremes();
      test_flat_window();
      test_discard_check();
      test_discard_off();
      test_output_backpressure();
      test_random_phases();
      drain_block();
      $display("Sent %0d samples through a %0d-sample window, checked %0d normalized words.",
               samples_sent, Window, words_checked);
      $display("Windows emitted: %0d, dropped by the start/end mean check: %0d.",
               windows_emitted, windows_dropped);
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
